// ----- rtl/lsrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lsrc_pkg;
  localparam int ROUTER_COUNT = 8;
  localparam int LINKS_PER_ROUTER = 8;
  localparam int LINK_ID_COUNT = 16;
  localparam int RW = $clog2(ROUTER_COUNT);
  localparam int SW = $clog2(LINKS_PER_ROUTER);
  localparam int CW = $clog2(LINKS_PER_ROUTER + 1);
  localparam int LW = $clog2(LINK_ID_COUNT);
  localparam int LDEPTH = ROUTER_COUNT * LINKS_PER_ROUTER;
  localparam int LAW = $clog2(LDEPTH);
  localparam logic [19:0] COST_TOP = 20'hFFFFF;
  // link store word: {link_id, cost}
  localparam int LDW = 5 + 16;
endpackage
`default_nettype wire

// ----- rtl/link_state_route_computer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Link-state route computer. Each input beat is one advertisement (router,
// link, cost). The link lists live in one synchronous RAM of
// ROUTER_COUNT*LINKS_PER_ROUTER words; every list scan reads one word at a
// time (address, then compare) through that single read port.
// A search run tests every destination from the own router once, then one
// row per settled router. An advertisement that changes nothing produces
// no output beats. After a change one beat per known router follows in
// ascending order, with last_entry marking the final one.
// The block holds one advertisement at a time; in_ready is low while busy.
// Path costs saturate at 2^20-1. own_router is sampled when a run starts.
module link_state_route_computer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  adv_router,
  input  wire logic [4:0]  link_id,
  input  wire logic [15:0] adv_cost,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       destination,
  output logic [3:0]       next_hop,
  output logic [19:0]      path_cost,
  output logic             is_local,
  output logic             reachable,
  output logic             last_entry
);
  localparam int N = lsrc_pkg::ROUTER_COUNT;
  localparam int RW = lsrc_pkg::RW;
  localparam int SW = lsrc_pkg::SW;
  localparam int CW = lsrc_pkg::CW;
  localparam int LW = lsrc_pkg::LW;
  localparam int LAW = lsrc_pkg::LAW;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_UREAD  = 12'b000000000010,
    S_UCHK   = 12'b000000000100,
    S_INIT   = 12'b000000001000,
    S_AREAD  = 12'b000000010000,
    S_ACHK   = 12'b000000100000,
    S_SEL    = 12'b000001000000,
    S_RELAX  = 12'b000010000000,
    S_EMIT   = 12'b000100000000,
    S_OUT    = 12'b001000000000,
    S_ANEXT  = 12'b010000000000,
    S_UWR    = 12'b100000000000
  } state_t;
  state_t state;

  logic [3:0] own_router;
  logic [N-1:0] known;
  logic [CW-1:0] lcount [N];
  logic [N-1:0] endp [lsrc_pkg::LINK_ID_COUNT];
  logic [19:0] best [N];
  logic [N-1:0] cvalid, settled;
  logic [3:0] fhop [N];

  logic [RW-1:0] ur;
  logic [LW-1:0] ul;
  logic [15:0] ucost;
  logic [SW-1:0] scan;
  logic [CW-1:0] scnt;
  logic [RW-1:0] pa, pb, w, emit_v;
  logic init_phase;
  logic [RW:0] src;
  logic [19:0] selc;
  logic selfound;

  logic we;
  logic [LAW-1:0] waddr, raddr;
  logic [lsrc_pkg::LDW-1:0] wdata, rdata;

  lsrc_ram #(.WIDTH(lsrc_pkg::LDW), .DEPTH(lsrc_pkg::LDEPTH)) u_links (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  wire logic [4:0] rd_lid = rdata[20:16];
  wire logic [15:0] rd_cost = rdata[15:0];
  wire logic [LW-1:0] rd_l = LW'(rd_lid - 5'd1);
  wire logic rd_lok = (rd_lid != 5'd0) && (32'(rd_lid) <= lsrc_pkg::LINK_ID_COUNT);
  wire logic rd_hit = rd_lok && endp[rd_l][pb];
  wire logic [20:0] tsum = 21'(best[w]) + 21'(rd_cost);
  wire logic [19:0] tsat = tsum[20] ? lsrc_pkg::COST_TOP : tsum[19:0];
  wire logic [19:0] cand = init_phase ? 20'(rd_cost) : tsat;
  wire logic more = 32'(scan) + 1 < 32'(scnt);

  assign in_ready = (state == S_IDLE);
  assign raddr = {pa, scan};

  always_comb begin
    we = 1'b0;
    waddr = {ur, scan};
    wdata = {5'(ul) + 5'd1, ucost};
    if (state == S_UWR) we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      known <= '0;
      own_router <= 4'd1;
      for (int i = 0; i < N; i++) lcount[i] <= '0;
      for (int i = 0; i < lsrc_pkg::LINK_ID_COUNT; i++) endp[i] <= '0;
    end else begin
      if (cfg_we) own_router <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ur <= RW'(adv_router - 4'd1);
            ul <= LW'(link_id - 5'd1);
            ucost <= adv_cost;
            pa <= RW'(adv_router - 4'd1);
            scan <= '0;
            if (adv_router != 4'd0 && 32'(adv_router) <= N && link_id != 5'd0 &&
                32'(link_id) <= lsrc_pkg::LINK_ID_COUNT) begin
              endp[LW'(link_id - 5'd1)][RW'(adv_router - 4'd1)] <= 1'b1;
              if (!known[RW'(adv_router - 4'd1)]) begin
                known[RW'(adv_router - 4'd1)] <= 1'b1;
                lcount[RW'(adv_router - 4'd1)] <= CW'(1);
                state <= S_UWR;
              end else if (lcount[RW'(adv_router - 4'd1)] == '0) begin
                state <= S_IDLE;
              end else begin
                state <= S_UREAD;
              end
            end
          end
        end
        S_UREAD: state <= S_UCHK;
        S_UCHK: begin
          if (rd_lid == 5'(ul) + 5'd1) begin
            state <= (rd_cost == ucost) ? S_IDLE : S_UWR;
          end else if (32'(scan) + 1 < 32'(lcount[ur])) begin
            scan <= scan + SW'(1);
            state <= S_UREAD;
          end else if (32'(lcount[ur]) >= lsrc_pkg::LINKS_PER_ROUTER) begin
            state <= S_IDLE;
          end else begin
            scan <= SW'(lcount[ur]);
            lcount[ur] <= lcount[ur] + CW'(1);
            state <= S_UWR;
          end
        end
        S_UWR: state <= S_INIT;
        S_INIT: begin
          src <= (own_router != 4'd0 && 32'(own_router) <= N) ?
                 (RW+1)'(own_router - 4'd1) : (RW+1)'(N);
          cvalid <= '0;
          for (int i = 0; i < N; i++) begin
            best[i] <= '0;
            fhop[i] <= '0;
          end
          init_phase <= 1'b1;
          pa <= RW'(own_router - 4'd1);
          w <= RW'(own_router - 4'd1);
          pb <= '0;
          scan <= '0;
          if (own_router != 4'd0 && 32'(own_router) <= N) begin
            settled <= N'(1) << RW'(own_router - 4'd1);
            state <= S_ANEXT;
          end else begin
            settled <= '0;
            emit_v <= '0;
            state <= S_EMIT;
          end
        end
        // test pair (pa,pb): needs both known and pb unsettled in relax
        S_ANEXT: begin
          scnt <= lcount[pa];
          scan <= '0;
          if (known[pa] && known[pb] && lcount[pa] != '0 &&
              (init_phase || !settled[pb]))
            state <= S_AREAD;
          else
            state <= S_RELAX;
        end
        S_AREAD: state <= S_ACHK;
        S_ACHK: begin
          if (rd_hit) begin
            if (init_phase) begin
              cvalid[pb] <= 1'b1;
              best[pb] <= cand;
              fhop[pb] <= 4'(pb) + 4'd1;
            end else if (!cvalid[pb] || cand < best[pb]) begin
              cvalid[pb] <= 1'b1;
              best[pb] <= cand;
              fhop[pb] <= fhop[w];
            end
            state <= S_RELAX;
          end else if (more) begin
            scan <= scan + SW'(1);
            state <= S_AREAD;
          end else begin
            state <= S_RELAX;
          end
        end
        // advance destination of current row
        S_RELAX: begin
          if (32'(pb) + 1 < N) begin
            pb <= pb + RW'(1);
            state <= S_ANEXT;
          end else begin
            init_phase <= 1'b0;
            pb <= '0;
            selfound <= 1'b0;
            state <= S_SEL;
          end
        end
        // linear minimum scan, one router per cycle
        S_SEL: begin
          if (known[pb] && !settled[pb] && cvalid[pb] &&
              (!selfound || best[pb] < selc)) begin
            selfound <= 1'b1;
            selc <= best[pb];
            w <= pb;
          end
          if (32'(pb) + 1 < N) begin
            pb <= pb + RW'(1);
          end else begin
            pb <= '0;
            if (selfound || (known[pb] && !settled[pb] && cvalid[pb])) begin
              if (known[pb] && !settled[pb] && cvalid[pb] &&
                  (!selfound || best[pb] < selc)) begin
                settled[pb] <= 1'b1;
                pa <= pb;
              end else begin
                settled[w] <= 1'b1;
                pa <= w;
              end
              state <= S_ANEXT;
            end else begin
              emit_v <= '0;
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (known[emit_v]) begin
            destination <= 4'(emit_v) + 4'd1;
            last_entry <= (known >> emit_v) == N'(1);
            if ({1'b0, emit_v} == src) begin
              next_hop <= '0; path_cost <= '0; is_local <= 1'b1; reachable <= 1'b1;
            end else if (cvalid[emit_v]) begin
              next_hop <= fhop[emit_v]; path_cost <= best[emit_v];
              is_local <= 1'b0; reachable <= 1'b1;
            end else begin
              next_hop <= '0; path_cost <= '0; is_local <= 1'b0; reachable <= 1'b0;
            end
            out_valid <= 1'b1;
            state <= S_OUT;
          end else if (32'(emit_v) + 1 < N) begin
            emit_v <= emit_v + RW'(1);
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_entry) state <= S_IDLE;
            else begin
              emit_v <= emit_v + RW'(1);
              state <= S_EMIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while emitting");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(destination))
    else $error("output dropped");
  a_src: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_local |-> reachable && next_hop == 4'd0)
    else $error("local entry malformed");
endmodule
`default_nettype wire

// ----- rtl/lsrc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lsrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
